FILE: rtl/abff_pkg.sv
// Shared types and constants of the allocation bitmap block.
// Depends on nothing; imported by the top level.
package abff_pkg;

  localparam int unsigned MAX_BITS = 1024;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned NUM_W   = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef enum logic [REQ_W-1:0] {
    REQ_SET       = 3'd0,
    REQ_CLEAR     = 3'd1,
    REQ_TEST      = 3'd2,
    REQ_FIND_FREE = 3'd3,
    REQ_CLEAR_ALL = 3'd4
  } req_e;

  // Result item, highest field first.
  typedef struct packed {
    logic             range_error;
    logic [CNT_W-1:0] used_count;
    logic [NUM_W-1:0] free_index;
    logic             found;
    logic             bit_value;
  } result_t;

endpackage

FILE: rtl/allocation_bitmap_first_free_core.sv
// Allocation bitmap: set / clear / test a bit, find the lowest clear bit, clear all.
// An in-range set, clear or test reads its word on accept, then writes it back if the
// bit changes; a find reads one word per step from word 0 until one has a clear bit or
// is the last below the size; other requests go to a finish state. One item is in work
// at a time; the next is taken once the last result is registered. The single RAM read
// port sets the scan pace. Reset is asynchronous: a per-word valid flag marks every word
// as zero at once, so no clearing pass is needed; size_in_use resets to 1024.
module allocation_bitmap_first_free_core
  import abff_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32   // power of two
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [SIZE_W-1:0]      cfg_wr_data_i,  // size_in_use
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] bit_number, rest zero
  input  logic [REQ_W-1:0]       s_axis_tuser,   // [2:0] req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // bit_value, found, free_index[9:0],
                                                 // used_count[10:0], range_error
);

  localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BA        = $clog2(WORD_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_q, state_d;
  req_e                 req_q, req_d;
  logic [BA-1:0]        pos_q, pos_d;
  logic [WA-1:0]        addr_q, addr_d;
  logic                 rerr_q, rerr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NUM_WORDS-1:0] valid_q, valid_d;
  logic                 vld_rd_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;
  logic [SIZE_W-1:0]    size_q;

  logic                 accept, out_free;
  logic [SIZE_W-1:0]    lim;
  logic [NUM_W-1:0]     in_num;
  req_e                 in_req;
  logic [31:0]          in_num32;
  logic                 in_range;

  logic                 ram_we, ram_re;
  logic [WA-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata, ram_wdata, word;
  logic                 old_bit;
  logic                 has_zero;
  logic [BA-1:0]        zero_pos;
  logic [31:0]          hit_idx, next_base;
  logic                 last_word;

  assign in_num   = s_axis_tdata[NUM_W-1:0];
  assign in_req   = req_e'(s_axis_tuser);
  assign in_num32 = 32'(in_num);
  assign lim      = (32'(size_q) > MAX_BITS) ? SIZE_W'(MAX_BITS) : size_q;
  assign in_range = in_num32 < 32'(lim);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Words never written since reset or clear-all read as zero.
  assign word    = vld_rd_q ? ram_rdata : '0;
  assign old_bit = word[pos_q];

  always_comb begin
    zero_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        zero_pos = BA'(b);
      end
    end
  end

  assign has_zero  = ~word != '0;
  assign hit_idx   = (32'(addr_q) << BA) | 32'(zero_pos);
  assign next_base = (32'(addr_q) + 32'd1) << BA;
  assign last_word = (32'(addr_q) == NUM_WORDS - 1) || (next_base >= 32'(lim));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    rerr_d      = rerr_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_wdata   = word;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d  = in_req;
          pos_d  = BA'(in_num32);
          addr_d = WA'(in_num32 >> BA);
          rerr_d = 1'b0;
          state_d = ST_FIN;
          case (in_req)
            REQ_SET, REQ_CLEAR, REQ_TEST: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = WA'(in_num32 >> BA);
                state_d   = ST_RMW;
              end else begin
                rerr_d = 1'b1;
              end
            end
            REQ_FIND_FREE: begin
              addr_d = '0;
              if (lim != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        if (out_free) begin
          if (req_q == REQ_SET && !old_bit) begin
            ram_we          = 1'b1;
            ram_wdata[pos_q] = 1'b1;
            cnt_d           = cnt_q + CNT_W'(1);
          end else if (req_q == REQ_CLEAR && old_bit) begin
            ram_we          = 1'b1;
            ram_wdata[pos_q] = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
          if (ram_we) begin
            valid_d[addr_q] = 1'b1;
          end
          out_d             = '0;
          out_d.bit_value   = old_bit;
          out_d.used_count  = cnt_d;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (has_zero || last_word) begin
          if (out_free) begin
            out_d            = '0;
            out_d.used_count = cnt_q;
            if (has_zero && hit_idx < 32'(lim)) begin
              out_d.found      = 1'b1;
              out_d.free_index = hit_idx[NUM_W-1:0];
            end
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_q + WA'(1);
          addr_d    = addr_q + WA'(1);
        end
      end

      ST_FIN: begin
        if (out_free) begin
          if (req_q == REQ_CLEAR_ALL) begin
            valid_d = '0;
            cnt_d   = '0;
          end
          out_d             = '0;
          out_d.range_error = rerr_q;
          out_d.used_count  = cnt_d;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
      size_q      <= SIZE_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (ram_re) begin
        vld_rd_q <= valid_q[ram_raddr];
      end
      if (cfg_wr_en_i) begin
        size_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pos_q  <= pos_d;
    addr_q <= addr_d;
    rerr_q <= rerr_d;
    out_q  <= out_d;
  end

  abff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_words (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Count of set bits can never exceed the map size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_BITS)
    else $error("set-bit count above map size");

  // A scan only looks at words that start below the limit.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (32'(addr_q) << BA) < 32'(lim))
    else $error("scan past size in use");

  // Write-back happens only while a set or clear is finishing.
  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_RMW && out_free &&
                (req_q == REQ_SET || req_q == REQ_CLEAR)))
    else $error("bitmap write outside read-modify-write");

endmodule

FILE: rtl/abff_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module abff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
